[rtl/hcbd_pkg.sv]
package hcbd_pkg;

    localparam int SIZE_BITS_DEF   = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int HEX_BITS        = 4;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // bytes dropped after the chunk data
    localparam logic [1:0] SKIP_LEN = 2'd2;

    // progress through CR LF CR LF in the trailer
    localparam logic [2:0] TM_NONE   = 3'd0;
    localparam logic [2:0] TM_CR     = 3'd1;
    localparam logic [2:0] TM_CRLF   = 3'd2;
    localparam logic [2:0] TM_CRLFCR = 3'd3;
    localparam logic [2:0] TM_FULL   = 3'd4;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_SKIP    = 3'd2,
        PH_TRAILER = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_DONE  = 2'd1,
        EV_ERROR = 2'd2
    } t_event;

    // classified byte, as queued between front and back
    typedef struct packed {
        logic [7:0]          data;
        logic                sob;
        logic                is_hex;
        logic [HEX_BITS-1:0] hex_val;
        logic                is_cr;
        logic                is_lf;
    } t_tok;

endpackage

[rtl/http_chunked_body_decoder.sv]
// Chunked body decoder: one byte per cycle sustained while the output is not held
// by back-pressure, with the back end updating the parser state as each byte is popped.
// A byte is written into the queue when it is taken; the back end parses it as it
// is popped, and any result is held in the output register until it is taken.
// A queue of QUEUE_DEPTH entries lets input and output stall independently.
// Sync reset (i_rst_n low): queue and output register emptied, size line expected.
module http_chunked_body_decoder import hcbd_pkg::*; #(
    parameter int SIZE_BITS   = SIZE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_start_of_body,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_data_byte
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             push, pop, full, empty;
    t_tok             tok_in, tok_out;
    logic [CNT_W-1:0] q_count;

    hcbd_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_body_byte     (i_body_byte),
        .i_start_of_body (i_start_of_body),
        .i_full          (full),
        .o_push          (push),
        .o_tok           (tok_in)
    );

    hcbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok_in),
        .i_pop   (pop),
        .o_tok   (tok_out),
        .o_full  (full),
        .o_empty (empty),
        .o_count (q_count)
    );

    hcbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_tok        (tok_out),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_data_byte  (o_data_byte)
    );

`ifndef SYNTH
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_ev_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_kind == EV_DATA || o_event_kind == EV_DONE ||
                         o_event_kind == EV_ERROR))
        else $error("bad event code");

    a_ctl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind != EV_DATA) |-> (o_data_byte == 8'h00))
        else $error("data byte not cleared on control event");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

[rtl/hcbd_front.sv]
module hcbd_front import hcbd_pkg::*; (
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_start_of_body,
    input  logic       i_full,
    output logic       o_push,
    output t_tok       o_tok
);

    always_comb begin
        o_tok         = '0;
        o_tok.data    = i_body_byte;
        o_tok.sob     = i_start_of_body;
        o_tok.is_cr   = (i_body_byte == CH_CR);
        o_tok.is_lf   = (i_body_byte == CH_LF);
        if (i_body_byte >= 8'h30 && i_body_byte <= 8'h39) begin
            o_tok.is_hex  = 1'b1;
            o_tok.hex_val = i_body_byte[3:0];
        end else if ((i_body_byte >= 8'h61 && i_body_byte <= 8'h66) ||
                     (i_body_byte >= 8'h41 && i_body_byte <= 8'h46)) begin
            // low three bits 1..6 map to 10..15 for both cases
            o_tok.is_hex  = 1'b1;
            o_tok.hex_val = 4'd9 + {1'b0, i_body_byte[2:0]};
        end
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

[rtl/hcbd_queue.sv]
module hcbd_queue import hcbd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_tok             i_tok,
    input  logic             i_pop,
    output t_tok             o_tok,
    output logic             o_full,
    output logic             o_empty,
    output logic [CNT_W-1:0] o_count
);

    t_tok             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    assign o_tok   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

[rtl/hcbd_back.sv]
module hcbd_back import hcbd_pkg::*; #(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_tok       i_tok,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_data_byte
);

    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_rem,   n_rem;
    logic                  r_hd,    n_hd;
    logic                  r_cr,    n_cr;
    logic [1:0]            r_skip,  n_skip;
    logic [2:0]            r_tm,    n_tm;
    logic                  r_out_valid, n_out_valid;
    t_event                r_event, n_event;
    logic [7:0]            r_data,  n_data;

    // start_of_body sees the reset state
    t_phase                c_phase;
    logic [SIZE_BITS-1:0]  c_rem;
    logic                  c_hd, c_cr;
    logic [1:0]            c_skip;
    logic [2:0]            c_tm;
    logic                  emit;
    t_event                ev;

    assign o_pop = !i_empty && (!r_out_valid || i_out_ready);

    always_comb begin
        c_phase = i_tok.sob ? PH_SIZE : r_phase;
        c_rem   = i_tok.sob ? '0      : r_rem;
        c_hd    = i_tok.sob ? 1'b0    : r_hd;
        c_cr    = i_tok.sob ? 1'b0    : r_cr;
        c_skip  = i_tok.sob ? '0      : r_skip;
        c_tm    = i_tok.sob ? TM_CRLF : r_tm;

        n_phase = r_phase;
        n_rem   = r_rem;
        n_hd    = r_hd;
        n_cr    = r_cr;
        n_skip  = r_skip;
        n_tm    = r_tm;
        emit    = 1'b0;
        ev      = EV_DATA;

        if (o_pop) begin
            n_phase = c_phase;
            n_rem   = c_rem;
            n_hd    = c_hd;
            n_cr    = c_cr;
            n_skip  = c_skip;
            n_tm    = c_tm;
            unique case (c_phase)
                PH_SIZE: begin
                    if (c_cr) begin
                        if (!i_tok.is_lf || !c_hd) begin
                            n_phase = PH_ERROR;
                            emit    = 1'b1;
                            ev      = EV_ERROR;
                        end else begin
                            n_cr = 1'b0;
                            n_hd = 1'b0;
                            if (c_rem == '0) begin
                                n_phase = PH_TRAILER;
                                n_tm    = TM_CRLF;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end else if (i_tok.is_cr) begin
                        n_cr = 1'b1;
                    end else if (!i_tok.is_hex ||
                                 c_rem[SIZE_BITS-1 -: HEX_BITS] != '0) begin
                        // bad character or the size would overflow
                        n_phase = PH_ERROR;
                        emit    = 1'b1;
                        ev      = EV_ERROR;
                    end else begin
                        n_rem = {c_rem[SIZE_BITS-HEX_BITS-1:0], i_tok.hex_val};
                        n_hd  = 1'b1;
                    end
                end
                PH_DATA: begin
                    n_rem = c_rem - 1'b1;
                    if (c_rem == SIZE_BITS'(1)) begin
                        n_phase = PH_SKIP;
                        n_skip  = SKIP_LEN;
                    end
                    emit = 1'b1;
                    ev   = EV_DATA;
                end
                PH_SKIP: begin
                    n_skip = c_skip - 1'b1;
                    if (c_skip == 2'd1) begin
                        n_phase = PH_SIZE;
                        n_rem   = '0;
                        n_hd    = 1'b0;
                        n_cr    = 1'b0;
                    end
                end
                PH_TRAILER: begin
                    if (i_tok.is_cr) begin
                        n_tm = (c_tm == TM_CRLF) ? TM_CRLFCR : TM_CR;
                    end else if (i_tok.is_lf) begin
                        n_tm = (c_tm == TM_CR)     ? TM_CRLF :
                               (c_tm == TM_CRLFCR) ? TM_FULL : TM_NONE;
                    end else begin
                        n_tm = TM_NONE;
                    end
                    if (n_tm == TM_FULL) begin
                        n_phase = PH_DONE;
                        emit    = 1'b1;
                        ev      = EV_DONE;
                    end
                end
                default: begin
                    // done or error: hold until the next start
                end
            endcase
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_event     = r_event;
        n_data      = r_data;
        if (emit) begin
            n_out_valid = 1'b1;
            n_event     = ev;
            n_data      = (ev == EV_DATA) ? i_tok.data : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_hd        <= 1'b0;
            r_cr        <= 1'b0;
            r_skip      <= '0;
            r_tm        <= TM_CRLF;
            r_out_valid <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_hd        <= n_hd;
            r_cr        <= n_cr;
            r_skip      <= n_skip;
            r_tm        <= n_tm;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_event <= n_event;
        r_data  <= n_data;
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_event;
    assign o_data_byte  = r_data;

endmodule

[tb/sv/http_chunked_body_decoder_tb.sv]
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
    import hcbd_pkg::*;

    localparam int SIZE_BITS    = SIZE_BITS_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 950;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_event     kind;
        logic [7:0] data;
    } t_body_event;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_body_byte;
    logic       i_start_of_body;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [1:0] o_event_kind;
    logic [7:0] o_data_byte;

    // decoder state as predicted
    t_phase               dec_phase;
    logic [SIZE_BITS-1:0] dec_count;
    logic                 dec_has_digit;
    logic                 dec_saw_cr;
    logic [1:0]           dec_skip;
    logic [2:0]           dec_match;

    t_body_event pending_events[$];
    logic [7:0]  msg_bytes[$];

    int mismatches  = 0;
    int n_data      = 0;
    int n_done      = 0;
    int n_error     = 0;
    int live_items  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int messages    = 0;

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_body_byte    (i_body_byte),
        .i_start_of_body(i_start_of_body),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_kind   (o_event_kind),
        .o_data_byte    (o_data_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void restart_decoder();
        dec_phase     = PH_SIZE;
        dec_count     = '0;
        dec_has_digit = 1'b0;
        dec_saw_cr    = 1'b0;
        dec_skip      = '0;
        dec_match     = TM_CRLF;
    endfunction

    function automatic void decode_step(input logic [7:0] b, input logic sob,
                                        output logic hit, output t_event kind,
                                        output logic [7:0] data);
        logic       is_hex;
        logic [3:0] nib;
        hit  = 1'b0;
        kind = EV_DATA;
        data = 8'h00;
        if (sob) restart_decoder();
        case (dec_phase)
            PH_SIZE: begin
                if (dec_saw_cr) begin
                    if (b != CH_LF || !dec_has_digit) begin
                        dec_phase = PH_ERROR;
                        hit       = 1'b1;
                        kind      = EV_ERROR;
                    end else begin
                        dec_saw_cr    = 1'b0;
                        dec_has_digit = 1'b0;
                        if (dec_count == 0) begin
                            dec_phase = PH_TRAILER;
                            dec_match = TM_CRLF;
                        end else begin
                            dec_phase = PH_DATA;
                        end
                    end
                end else if (b == CH_CR) begin
                    dec_saw_cr = 1'b1;
                end else begin
                    // low nibble is the value for digits; letters sit at 1..6
                    is_hex = 1'b1;
                    nib    = b[3:0];
                    if (b >= "0" && b <= "9") begin
                        nib = b[3:0];
                    end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
                        nib = b[3:0] + 4'd9;
                    end else begin
                        is_hex = 1'b0;
                    end
                    if (!is_hex || dec_count[SIZE_BITS-1 -: 4] != 0) begin
                        dec_phase = PH_ERROR;
                        hit       = 1'b1;
                        kind      = EV_ERROR;
                    end else begin
                        dec_count     = {dec_count[SIZE_BITS-5:0], nib};
                        dec_has_digit = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                dec_count = dec_count - 1'b1;
                if (dec_count == 0) begin
                    dec_phase = PH_SKIP;
                    dec_skip  = SKIP_LEN;
                end
                hit  = 1'b1;
                kind = EV_DATA;
                data = b;
            end
            PH_SKIP: begin
                dec_skip = dec_skip - 1'b1;
                if (dec_skip == 0) begin
                    dec_phase     = PH_SIZE;
                    dec_count     = '0;
                    dec_has_digit = 1'b0;
                    dec_saw_cr    = 1'b0;
                end
            end
            PH_TRAILER: begin
                if (b == CH_CR) begin
                    dec_match = (dec_match == TM_CRLF) ? TM_CRLFCR : TM_CR;
                end else if (b == CH_LF) begin
                    dec_match = (dec_match == TM_CR)     ? TM_CRLF :
                                (dec_match == TM_CRLFCR) ? TM_FULL : TM_NONE;
                end else begin
                    dec_match = TM_NONE;
                end
                if (dec_match == TM_FULL) begin
                    dec_phase = PH_DONE;
                    hit       = 1'b1;
                    kind      = EV_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    endfunction

    always @(posedge i_clk) begin : check_results
        logic        hit;
        t_event      kind;
        logic [7:0]  data;
        t_body_event rec;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                live_items++;
                decode_step(i_body_byte, i_start_of_body, hit, kind, data);
                if (hit) begin
                    rec.kind = kind;
                    rec.data = data;
                    pending_events.insert(pending_events.size(), rec);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_events.size() == 0) begin
                    note_mismatch($sformatf("result with none pending: kind %0d data %02h",
                                            o_event_kind, o_data_byte));
                end else begin
                    rec = pending_events.pop_front();
                    if (rec.kind == EV_DATA) n_data++;
                    else if (rec.kind == EV_DONE) n_done++;
                    else n_error++;
                    if (o_event_kind != rec.kind || o_data_byte != rec.data)
                        note_mismatch($sformatf(
                            "expected kind %0d data %02h, got kind %0d data %02h",
                            rec.kind, rec.data, o_event_kind, o_data_byte));
                end
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure, switching between patterns
    initial begin
        t_rx_mode rx_mode;
        int       rx_left;
        i_out_ready = 1'b1;
        rx_mode     = RX_OPEN;
        rx_left     = 0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 60);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:     i_out_ready = 1'b1;
                RX_COIN:     i_out_ready = 1'($urandom_range(0, 1));
                RX_SPARSE:   i_out_ready = ($urandom_range(0, 3) == 0);
                RX_PERIODIC: i_out_ready = ((rx_left % 11) >= 8);
                default:     i_out_ready = 1'b1;
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sob);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      = 1'b1;
        i_body_byte     = b;
        i_start_of_body = sob;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_message();
        for (int k = 0; k < msg_bytes.size(); k++) send_byte(msg_bytes[k], k == 0);
        msg_bytes.delete();
        messages++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        msg_bytes.insert(msg_bytes.size(), b);
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endfunction

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        int d;
        d = v % 16;
        if (d < 10) return 8'(8'h30 + d);
        return 8'((($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + d - 10);
    endfunction

    function automatic logic [7:0] noise_byte();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) return CH_CR;
        if (pick == 1) return CH_LF;
        if (pick == 2) return ";";
        if (pick == 3) return " ";
        if (pick == 4) return "g";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_size_line(input int unsigned v);
        int ndig;
        ndig = 1;
        while (ndig < 8 && (v >> (4 * ndig)) != 0) ndig++;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) add_byte("0");
        for (int k = ndig - 1; k >= 0; k--) add_byte(hex_char(int'(v >> (4 * k))));
        add_crlf();
    endfunction

    function automatic void add_chunk(input int n);
        add_size_line(n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        // the two bytes after the data are dropped unchecked
        if ($urandom_range(0, 1) != 0) begin
            add_crlf();
        end else begin
            add_byte(8'($urandom_range(0, 255)));
            add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void add_trailer();
        int pick;
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            add_crlf();
        end else if (pick == 2) begin
            repeat ($urandom_range(1, 2)) begin
                repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(8'h20, 8'h7e)));
                add_crlf();
            end
            add_crlf();
        end else begin
            // stray CR, LF and 'x' bytes ahead of a full terminator
            repeat ($urandom_range(2, 6)) begin
                case ($urandom_range(0, 2))
                    0:       add_byte(CH_CR);
                    1:       add_byte(CH_LF);
                    default: add_byte("x");
                endcase
            end
            add_crlf();
            add_crlf();
        end
    endfunction

    function automatic void build_random_message();
        int pick;
        int cut;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            repeat ($urandom_range(1, 8)) add_byte(noise_byte());
        end else if (pick < 11) begin
            // long size lines: near the top of the range or past it
            repeat ($urandom_range(7, 10)) add_byte(hex_char(int'($urandom_range(0, 15))));
            add_crlf();
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 4))
                add_chunk(($urandom_range(0, 7) == 0) ? $urandom_range(9, 64)
                                                       : $urandom_range(1, 8));
            add_size_line(0);
            add_trailer();
            if (pick < 20) begin
                cut = $urandom_range(0, msg_bytes.size() - 1);
                msg_bytes[cut] = noise_byte();
            end else if (pick < 26) begin
                cut = $urandom_range(1, msg_bytes.size() - 1);
                while (msg_bytes.size() > cut) msg_bytes.delete(msg_bytes.size() - 1);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic test_chunk_and_trailer();
        push_text("2");
        add_crlf();
        add_byte(8'h00);
        add_byte(8'hFF);
        push_text("xy");
        push_text("0");
        add_crlf();
        // stray CR in the trailer restarts the terminator match
        add_byte(CH_CR);
        add_crlf();
        add_crlf();
        push_text("Z");
        send_message();
        wait_drained();
    endtask

    task automatic test_size_line_errors();
        add_crlf();
        push_text("5");
        send_message();
        add_byte(CH_LF);
        send_message();
        push_text("1");
        add_byte(CH_CR);
        push_text("x");
        send_message();
        push_text("g");
        send_message();
        wait_drained();
    endtask

    task automatic test_size_overflow();
        // eight digits fit, the ninth overflows
        push_text("fFfFfFfF0");
        send_message();
        wait_drained();
    endtask

    task automatic test_random_messages();
        live_items = 0;
        while (live_items < RANDOM_BYTES) begin
            build_random_message();
            send_message();
            if (messages % 12 == 0) wait_drained();
        end
        wait_drained();
    endtask

    task automatic finish_run();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("ran %0d messages (well-formed, corrupted, cut short, noise, oversized sizes)",
                 messages);
        $display("checked %0d body bytes, %0d completions, %0d size errors; %0d mismatches",
                 n_data, n_done, n_error, mismatches);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_body_byte     = 8'h00;
        i_start_of_body = 1'b0;
        restart_decoder();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_chunk_and_trailer();
        test_size_line_errors();
        test_size_overflow();
        test_random_messages();
        finish_run();
    end

endmodule
